// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/ibus_ia6_pkg.sv
// Package for the iBus frame decoder: codes, constants and the structs
// passed between the stages. No dependencies.
`timescale 1ns / 1ps
package ibus_ia6_pkg;

    localparam int unsigned CHANNEL_LIMIT = 8;
    localparam int unsigned FRAME_BYTES   = 31;

    typedef logic [1:0] t_op;
    localparam t_op OP_BYTE    = 2'd0;
    localparam t_op OP_GAP     = 2'd1;
    localparam t_op OP_TIMEOUT = 2'd2;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_UPDATE = 2'd0;
    localparam t_kind KIND_GOOD   = 2'd1;
    localparam t_kind KIND_FAIL   = 2'd2;

    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_MAGIC     = 1'b0;
    localparam t_cfg_idx CFG_MAX_FAILS = 1'b1;

    localparam logic [7:0] MAGIC_RESET     = 8'h55;
    localparam logic [7:0] MAX_FAILS_RESET = 8'd3;
    localparam logic [7:0] FAIL_SAT        = 8'hFF;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_FRAME,
        MODE_STOP
    } t_mode;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  channel_index;
        logic [11:0] channel_value;
        logic [7:0]  fail_count;
        logic        stopped;
    } t_result;

endpackage

// File: rtl/ibus_ia6_in_stage.sv
// Input register of the iBus frame decoder.
// Depends on ibus_ia6_pkg for the item struct.
`timescale 1ns / 1ps
module ibus_ia6_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ibus_ia6_pkg::t_item i_item,
    input  logic                i_take,
    output logic                o_item_valid,
    output ibus_ia6_pkg::t_item o_item
);
    import ibus_ia6_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_ready      = i_rst_n && (!r_valid || i_take);
    assign accept       = i_valid && o_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule

// File: rtl/ibus_ia6_core.sv
// Frame state machine, checksum and failure counter of the iBus decoder.
// Depends on ibus_ia6_pkg for codes, constants and structs.
`timescale 1ns / 1ps
module ibus_ia6_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  ibus_ia6_pkg::t_cfg_idx   i_cfg_index,
    input  logic [7:0]               i_cfg_data,
    input  logic                     i_fire,
    input  ibus_ia6_pkg::t_item      i_item,
    output logic                     o_has_result,
    output ibus_ia6_pkg::t_result    o_result
);
    import ibus_ia6_pkg::*;

    localparam logic [5:0] FB = 6'(FRAME_BYTES);
    localparam logic [4:0] CL = 5'(CHANNEL_LIMIT);

    logic [7:0]  r_magic, r_max_fails;
    t_mode       r_mode, n_mode;
    logic [4:0]  r_pos, n_pos;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_hold, n_hold;
    logic        r_matched, n_matched;
    logic [7:0]  r_failures, n_failures;

    logic [7:0]  b;
    logic [5:0]  p6;
    logic [15:0] word;
    logic [3:0]  ch;
    logic        halted, at_limit, live, is_timeout, in_byte;
    logic        is_first, is_last, csum_ok, frame_good, frame_fail;
    logic        mid, take_low, word_done, upd, any_fail, fail_stop;
    logic [7:0]  fail_inc;

    assign b          = i_item.data_byte;
    assign p6         = {1'b0, r_pos};
    assign word       = {b, r_hold};
    assign ch         = 4'((r_pos - 5'd2) >> 1);
    assign halted     = (r_mode == MODE_STOP);
    assign at_limit   = (r_failures >= r_max_fails);
    assign live       = !halted && !at_limit;
    assign is_timeout = live && (i_item.op == OP_TIMEOUT);
    assign in_byte    = live && (r_mode == MODE_FRAME) && (i_item.op == OP_BYTE);
    assign is_first   = in_byte && (r_pos == 5'd0);
    assign is_last    = in_byte && (r_pos != 5'd0) && (p6 + 6'd1 >= FB);
    assign csum_ok    = r_matched && (word == r_sum);
    assign frame_good = is_last && csum_ok;
    assign frame_fail = is_last && !csum_ok;
    assign mid        = in_byte && (r_pos != 5'd0) && !is_last;
    // Low byte of a word, or the low checksum byte.
    assign take_low   = mid && ((p6 + 6'd2 == FB) || r_pos[0]);
    // Drop the lone byte before the checksum on even frame lengths.
    assign word_done  = mid && !take_low && !(p6 + 6'd3 > FB);
    assign upd        = word_done && r_matched && ({1'b0, ch} < CL);
    assign any_fail   = is_timeout || frame_fail;
    assign fail_inc   = (r_failures == FAIL_SAT) ? FAIL_SAT : r_failures + 8'd1;
    assign fail_stop  = (fail_inc >= r_max_fails);

    // Next state.
    always_comb begin
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_hold     = r_hold;
        n_matched  = r_matched;
        n_failures = r_failures;
        if (i_fire && !halted) begin
            if (at_limit) begin
                n_mode = MODE_STOP;
            end else if (any_fail) begin
                n_failures = fail_inc;
                n_mode     = fail_stop ? MODE_STOP : MODE_HUNT;
                n_pos      = 5'd0;
            end else if (r_mode == MODE_HUNT && i_item.op == OP_GAP) begin
                n_mode = MODE_FRAME;
                n_pos  = 5'd0;
            end
            if (is_first) begin
                n_matched = (b == r_magic);
                n_sum     = 16'd0;
                n_pos     = 5'd1;
            end
            if (frame_good) begin
                n_failures = 8'd0;
                n_pos      = 5'd0;
            end
            if (mid) begin
                n_pos = r_pos + 5'd1;
            end
            if (take_low) begin
                n_hold = b;
            end
            if (word_done) begin
                n_sum = r_sum + word;
            end
        end
    end

    // Result.
    always_comb begin
        o_has_result = 1'b0;
        o_result     = '0;
        if (any_fail) begin
            o_has_result        = 1'b1;
            o_result.kind       = KIND_FAIL;
            o_result.fail_count = fail_inc;
            o_result.stopped    = fail_stop;
        end else if (frame_good) begin
            o_has_result  = 1'b1;
            o_result.kind = KIND_GOOD;
        end else if (upd) begin
            o_has_result           = 1'b1;
            o_result.kind          = KIND_UPDATE;
            o_result.channel_index = ch;
            o_result.channel_value = word[11:0];
            o_result.fail_count    = r_failures;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic     <= MAGIC_RESET;
            r_max_fails <= MAX_FAILS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAGIC:     r_magic     <= i_cfg_data;
                CFG_MAX_FAILS: r_max_fails <= i_cfg_data;
                default:       r_magic     <= r_magic;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_HUNT;
            r_pos      <= 5'd0;
            r_sum      <= 16'd0;
            r_hold     <= 8'd0;
            r_matched  <= 1'b0;
            r_failures <= 8'd0;
        end else begin
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_hold     <= n_hold;
            r_matched  <= n_matched;
            r_failures <= n_failures;
        end
    end

endmodule

// File: rtl/ibus_ia6_out_stage.sv
// Result register of the iBus frame decoder.
// Depends on ibus_ia6_pkg for the result struct.
`timescale 1ns / 1ps
module ibus_ia6_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  ibus_ia6_pkg::t_result i_result,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ibus_ia6_pkg::t_result o_result
);
    import ibus_ia6_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/ibus_ia6_frame_decoder_unit.sv
// Top level of the iBus frame decoder: input register, frame core, result register.
// Depends on ibus_ia6_pkg, ibus_ia6_in_stage, ibus_ia6_core, ibus_ia6_out_stage.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one transaction per UART byte
//   (op byte), interframe gap (op gap) or timeout (op timeout).
//   Output channel (o_valid / i_ready) carries channel updates, frame-good
//   reports and failure reports; a transaction yields zero or one result.
//   Configuration: write i_cfg_data to register i_cfg_index (0 magic byte,
//   1 failure limit) while i_cfg_we is high; write only while the block is idle.
// Timing:
//   One transaction per cycle sustained while the result register is free.
//   A result reaches o_valid by way of both registers: the item waits in
//   the input register while the frame core decodes it into the result register.
//   The frame core computes all its counter updates combinationally, so the
//   rate is set by the input register handing over one item per clock.
// Reset (synchronous, i_rst_n low): hunt for a gap, clear counters and
//   failures, restore magic 0x55 and limit 3; o_ready stays low.
// Stall: when i_ready is low the result register holds; the input register
//   still takes one transaction, then o_ready drops until the result drains.
`timescale 1ns / 1ps
module ibus_ia6_frame_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_channel_index,
    output logic [11:0] o_channel_value,
    output logic [7:0]  o_fail_count,
    output logic        o_stopped
);
    import ibus_ia6_pkg::*;

    t_item   in_item, stage_item;
    t_result core_result, out_result;
    logic    stage_valid, core_has_result, out_free, fire;

    assign in_item.op        = i_op;
    assign in_item.data_byte = i_data_byte;

    // Advance the held item whenever the result register can take its result.
    assign fire = stage_valid && out_free;

    ibus_ia6_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .i_take       (fire),
        .o_item_valid (stage_valid),
        .o_item       (stage_item)
    );

    ibus_ia6_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_fire       (fire),
        .i_item       (stage_item),
        .o_has_result (core_has_result),
        .o_result     (core_result)
    );

    ibus_ia6_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && core_has_result),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_kind          = out_result.kind;
    assign o_channel_index = out_result.channel_index;
    assign o_channel_value = out_result.channel_value;
    assign o_fail_count    = out_result.fail_count;
    assign o_stopped       = out_result.stopped;

endmodule

// File: rtl/ibus_ia6_checker.sv
// Port-level checker for the iBus frame decoder, bound to the top level.
// Depends on ibus_ia6_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ibus_ia6_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_kind,
    input logic [3:0]  o_channel_index,
    input logic [11:0] o_channel_value,
    input logic [7:0]  o_fail_count,
    input logic        o_stopped
);
    import ibus_ia6_pkg::*;

    // A stalled result holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_kind) && $stable(o_channel_value) && $stable(o_fail_count))

    // A good frame clears the failure run and never stops the block.
    `ASSERT_SAME(a_good_clean, i_clk, i_rst_n, o_valid && o_kind == KIND_GOOD, o_fail_count == 8'd0 && !o_stopped)

    // Only a failure can report the stop.
    `ASSERT_SAME(a_stop_is_fail, i_clk, i_rst_n, o_valid && o_stopped, o_kind == KIND_FAIL)

    // Updates name a channel below the limit.
    `ASSERT_SAME(a_chan_range, i_clk, i_rst_n, o_valid && o_kind == KIND_UPDATE, {1'b0, o_channel_index} < 5'(CHANNEL_LIMIT) && !o_stopped)

    // Nothing follows the stop report.
    `ASSERT_NEXT(a_quiet_after_stop, i_clk, i_rst_n, o_valid && i_ready && o_stopped, !o_valid)

endmodule

bind ibus_ia6_frame_decoder_unit ibus_ia6_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_kind          (o_kind),
    .o_channel_index (o_channel_index),
    .o_channel_value (o_channel_value),
    .o_fail_count    (o_fail_count),
    .o_stopped       (o_stopped)
);
